@@ design/cmmn_pkg.sv @@
package cmmn_pkg;

  localparam int unsigned SAMPLE_W  = 48;
  localparam int unsigned COL_W     = 6;
  // Differences of two samples need one bit more than a sample.
  localparam int unsigned DIFF_W    = SAMPLE_W + 1;
  localparam int unsigned S_TDATA_W = 56;
  localparam int unsigned M_TDATA_W = 56;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TUSER_W = 1;

  // Sentinels for a column that has no statistics yet, in whole units.
  localparam longint SENT_MAX_UNITS = -64'sd999999;
  localparam longint SENT_MIN_UNITS = 64'sd9999999;

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ACCUM = 2'd1,
    CMD_NORM  = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_ACCUM,
    ST_CALC,
    ST_START,
    ST_DIVIDE,
    ST_RESULT
  } state_e;

endpackage

@@ design/column_min_max_normalizer.sv @@
// Per-column min-max normalizer on signed fixed-point samples.
//
// Input stream (s_axis): one word per command. tuser carries the command:
// clear statistics, accumulate a sample into its column's max/min, or
// normalize a sample. Clear and accumulate produce no output word.
// Output stream (m_axis): one word per normalize command carrying
// (x - min) / (max - min) saturated to 48 bits, the column, and a
// no-statistics flag that is set (with the sample passed through) when no
// clear has been seen since reset. Equal max and min give one half.
//
// Steps: clear acts on accept; accumulate passes accept, statistics memory
// read and write back. Normalize passes accept, memory read, operand set-up,
// divider start, the bit-serial divider (one quotient bit per cycle), and the
// result. Equal max and min skip the divider; pass-through skips to result.
// One command is in work at a time; s_axis_tready_o is high only when idle.
// A finished result sits in an output register, so a stalled receiver only
// blocks the block when a second result is ready before the first is taken.
// Reset clears the seen bits and the statistics flag; max/min storage is
// not cleared and is never used for a column whose seen bit is low.
module column_min_max_normalizer #(
  parameter int unsigned NUM_COLUMNS   = 64,
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [5:0] column, [53:6] sample, [55:54] zero
  input  logic [cmmn_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // [1:0] command
  input  logic [cmmn_pkg::S_TUSER_W-1:0]   s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [47:0] normalized, [53:48] out_column, [55:54] zero
  output logic [cmmn_pkg::M_TDATA_W-1:0]   m_axis_tdata_o,
  // [0] no_statistics
  output logic [cmmn_pkg::M_TUSER_W-1:0]   m_axis_tuser_o
);

  localparam int unsigned SW = cmmn_pkg::SAMPLE_W;
  localparam int unsigned DW = cmmn_pkg::DIFF_W;
  localparam int unsigned CLW = cmmn_pkg::COL_W;
  // Only columns reachable by the column field need storage.
  localparam int unsigned NC = (NUM_COLUMNS < (1 << CLW)) ? NUM_COLUMNS : (1 << CLW);
  localparam int unsigned AW = (NC > 1) ? $clog2(NC) : 1;

  localparam longint Sat48Max = (64'sd1 <<< (SW - 1)) - 64'sd1;
  localparam longint Sat48Min = -(64'sd1 <<< (SW - 1));
  localparam longint SentMaxRaw = cmmn_pkg::SENT_MAX_UNITS * (64'sd1 <<< FRACTION_BITS);
  localparam longint SentMinRaw = cmmn_pkg::SENT_MIN_UNITS * (64'sd1 <<< FRACTION_BITS);
  localparam longint SentMaxSat = (SentMaxRaw < Sat48Min) ? Sat48Min :
                                  ((SentMaxRaw > Sat48Max) ? Sat48Max : SentMaxRaw);
  localparam longint SentMinSat = (SentMinRaw < Sat48Min) ? Sat48Min :
                                  ((SentMinRaw > Sat48Max) ? Sat48Max : SentMinRaw);
  localparam logic signed [SW-1:0] SentMax = SW'(SentMaxSat);
  localparam logic signed [SW-1:0] SentMin = SW'(SentMinSat);
  localparam logic signed [SW-1:0] Half = SW'(64'sd1 <<< (FRACTION_BITS - 1));

  cmmn_pkg::state_e state_q, state_d;

  // Input word fields
  logic [CLW-1:0]          in_col;
  logic signed [SW-1:0]    in_sample;
  cmmn_pkg::cmd_e          in_cmd;
  logic                    in_accept;
  logic                    in_col_valid;

  // Captured command
  logic [CLW-1:0]          col_q;
  logic [AW-1:0]           addr_q;
  logic signed [SW-1:0]    x_q;
  logic                    is_norm_q;
  logic                    col_valid_q;

  // Statistics storage: {max, min} per column, plus seen bits
  logic [2*SW-1:0]         stat_mem_q [NC];
  logic [2*SW-1:0]         rd_q;
  logic [NC-1:0]           seen_q;
  logic                    stats_q;

  logic signed [SW-1:0]    rd_max, rd_min, new_max, new_min, use_max, use_min;
  logic                    hit;

  // Divider operands and result
  logic signed [DW-1:0]    num_q, den_q;
  logic                    div_start, div_busy, div_done;
  logic signed [SW-1:0]    div_quot;

  logic signed [SW-1:0]    res_q;
  logic                    res_flag_q;

  // Output register
  logic                    out_valid_q;
  logic signed [SW-1:0]    out_norm_q;
  logic [CLW-1:0]          out_col_q;
  logic                    out_flag_q;
  logic                    out_load;
  logic                    mem_we;

  assign in_col    = s_axis_tdata_i[CLW-1:0];
  assign in_sample = $signed(s_axis_tdata_i[CLW+SW-1:CLW]);
  assign in_cmd    = cmmn_pkg::cmd_e'(s_axis_tuser_i);
  assign in_accept = s_axis_tvalid_i && s_axis_tready_o;
  assign in_col_valid = {1'b0, in_col} < (CLW + 1)'(NC);

  assign rd_max  = $signed(rd_q[2*SW-1:SW]);
  assign rd_min  = $signed(rd_q[SW-1:0]);
  assign hit     = col_valid_q && seen_q[addr_q];
  assign use_max = hit ? rd_max : SentMax;
  assign use_min = hit ? rd_min : SentMin;
  // First sample of a column replaces the sentinels outright.
  assign new_max = (!seen_q[addr_q] || (x_q >= rd_max)) ? x_q : rd_max;
  assign new_min = (!seen_q[addr_q] || (x_q <= rd_min)) ? x_q : rd_min;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cmmn_pkg::ST_IDLE: begin
        if (in_accept) begin
          case (in_cmd)
            cmmn_pkg::CMD_ACCUM: begin
              if (stats_q && in_col_valid) state_d = cmmn_pkg::ST_READ;
            end
            cmmn_pkg::CMD_NORM: begin
              state_d = stats_q ? cmmn_pkg::ST_READ : cmmn_pkg::ST_RESULT;
            end
            default: state_d = cmmn_pkg::ST_IDLE;
          endcase
        end
      end
      cmmn_pkg::ST_READ:   state_d = is_norm_q ? cmmn_pkg::ST_CALC : cmmn_pkg::ST_ACCUM;
      cmmn_pkg::ST_ACCUM:  state_d = cmmn_pkg::ST_IDLE;
      cmmn_pkg::ST_CALC:   state_d = (use_max == use_min) ? cmmn_pkg::ST_RESULT
                                                          : cmmn_pkg::ST_START;
      cmmn_pkg::ST_START:  state_d = cmmn_pkg::ST_DIVIDE;
      cmmn_pkg::ST_DIVIDE: begin
        if (div_done) state_d = cmmn_pkg::ST_RESULT;
      end
      cmmn_pkg::ST_RESULT: begin
        if (out_load) state_d = cmmn_pkg::ST_IDLE;
      end
      default: state_d = cmmn_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    div_start       = 1'b0;
    mem_we          = 1'b0;
    out_load        = 1'b0;
    case (state_q)
      cmmn_pkg::ST_IDLE:   s_axis_tready_o = 1'b1;
      cmmn_pkg::ST_ACCUM:  mem_we = 1'b1;
      cmmn_pkg::ST_START:  div_start = 1'b1;
      cmmn_pkg::ST_RESULT: out_load = !out_valid_q || m_axis_tready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cmmn_pkg::ST_IDLE;
      stats_q     <= 1'b0;
      seen_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_accept && (in_cmd == cmmn_pkg::CMD_CLEAR)) begin
        seen_q  <= '0;
        stats_q <= 1'b1;
      end
      if (mem_we) seen_q[addr_q] <= 1'b1;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture the word and hold it while the command is in work.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      col_q       <= in_col;
      addr_q      <= AW'(in_col);
      x_q         <= in_sample;
      is_norm_q   <= (in_cmd == cmmn_pkg::CMD_NORM);
      col_valid_q <= in_col_valid;
      res_q       <= in_sample;
      res_flag_q  <= 1'b1;
    end
    if (state_q == cmmn_pkg::ST_CALC) begin
      num_q      <= DW'(x_q) - DW'(use_min);
      den_q      <= DW'(use_max) - DW'(use_min);
      res_q      <= Half;
      res_flag_q <= 1'b0;
    end
    if ((state_q == cmmn_pkg::ST_DIVIDE) && div_done) res_q <= div_quot;
    if (out_load) begin
      out_norm_q <= res_q;
      out_col_q  <= col_q;
      out_flag_q <= res_flag_q;
    end
  end

  // Statistics memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) stat_mem_q[addr_q] <= {new_max, new_min};
    rd_q <= stat_mem_q[addr_q];
  end

  cmmn_div #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num_q),
    .den_i  (den_q),
    .busy_o (div_busy),
    .done_o (div_done),
    .quot_o (div_quot)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {{(cmmn_pkg::M_TDATA_W - SW - CLW){1'b0}}, out_col_q, out_norm_q};
  assign m_axis_tuser_o  = out_flag_q;

  a_idle_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> !div_busy)
    else $error("input accepted while divider busy");

  a_done_in_divide: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == cmmn_pkg::ST_DIVIDE))
    else $error("divider finished outside divide state");

  a_clear_sets_stats: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && (in_cmd == cmmn_pkg::CMD_CLEAR)) |=> (stats_q && (seen_q == '0)))
    else $error("clear did not reset statistics");

  a_write_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (stats_q && col_valid_q && !is_norm_q))
    else $error("statistics written for an ignored command");

endmodule

@@ design/cmmn_div.sv @@
// Radix-2 restoring divider: (|num| << FRACTION_BITS) / |den|, one quotient
// bit per cycle, signed and saturated to the sample width.
module cmmn_div #(
  parameter int unsigned FRACTION_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic signed [cmmn_pkg::DIFF_W-1:0]  num_i,
  input  logic signed [cmmn_pkg::DIFF_W-1:0]  den_i,
  output logic                                busy_o,
  output logic                                done_o,
  output logic signed [cmmn_pkg::SAMPLE_W-1:0] quot_o
);

  localparam int unsigned DW = cmmn_pkg::DIFF_W;
  localparam int unsigned SW = cmmn_pkg::SAMPLE_W;
  localparam int unsigned NB = DW + FRACTION_BITS;
  localparam int unsigned CW = $clog2(NB + 1);

  logic [NB-1:0] dvd_q, quo_q;
  logic [DW-1:0] rem_q, dvs_q;
  logic          neg_q, busy_q, done_q;
  logic [CW-1:0] cnt_q;

  logic [DW-1:0] num_mag, den_mag;
  logic [DW:0]   trial;
  logic [DW+1:0] diff;

  assign num_mag = num_i[DW-1] ? DW'(-num_i) : DW'(num_i);
  assign den_mag = den_i[DW-1] ? DW'(-den_i) : DW'(den_i);
  assign trial   = {rem_q, dvd_q[NB-1]};
  assign diff    = {1'b0, trial} - {2'b00, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(NB);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= {num_mag, {FRACTION_BITS{1'b0}}};
      dvs_q <= den_mag;
      rem_q <= '0;
      quo_q <= '0;
      neg_q <= num_i[DW-1] ^ den_i[DW-1];
    end else if (busy_q) begin
      dvd_q <= {dvd_q[NB-2:0], 1'b0};
      if (!diff[DW+1]) begin
        rem_q <= diff[DW-1:0];
        quo_q <= {quo_q[NB-2:0], 1'b1};
      end else begin
        rem_q <= trial[DW-1:0];
        quo_q <= {quo_q[NB-2:0], 1'b0};
      end
    end
  end

  // Saturate: positive above max, negative beyond the most negative value.
  always_comb begin
    if (neg_q) begin
      if ((|quo_q[NB-1:SW]) || (quo_q[SW-1] && (|quo_q[SW-2:0]))) begin
        quot_o = {1'b1, {(SW-1){1'b0}}};
      end else begin
        quot_o = -$signed(quo_q[SW-1:0]);
      end
    end else begin
      if (|quo_q[NB-1:SW-1]) begin
        quot_o = {1'b0, {(SW-1){1'b1}}};
      end else begin
        quot_o = $signed(quo_q[SW-1:0]);
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule
